// File: rtl/core/mexp_pkg.sv
package mexp_pkg;

  // Default operand width
  localparam int OPERAND_WIDTH_DEF = 64;

  // Microprogram geometry
  localparam int UCODE_DEPTH = 11;
  localparam int PC_W        = 4;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_TEST,      // branch only
    OP_REDUCE,    // b = b mod m
    OP_INIT_ACC,  // acc = 1 mod m
    OP_MUL_ACC,   // acc = acc * b mod m
    OP_SQR_B,     // b = b * b mod m
    OP_SHIFT_E,   // e = e >> 1
    OP_OUT_ACC,   // emit acc, end of program
    OP_OUT_ERR,   // emit zero-modulus error
    OP_OUT_ONE    // emit 1 for zero exponent
  } op_t;

  // Branch conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_M_ZERO,
    COND_E_ZERO,
    COND_E_LSB_CLEAR,
    COND_E_REST_NZ   // exponent after shift still nonzero
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // Command to the modular multiply unit
  typedef struct packed {
    logic go;
    logic reduce;   // reduce y mod m instead of x * y mod m
  } mm_cmd_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_LOOP = PC_W'(4);
  localparam logic [PC_W-1:0] PC_SQR  = PC_W'(6);
  localparam logic [PC_W-1:0] PC_ERR  = PC_W'(9);
  localparam logic [PC_W-1:0] PC_ONE  = PC_W'(10);

  // Control store: right-to-left square-and-multiply
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_TEST, cond: COND_NEVER, target: '0};
    case (pc)
      PC_W'(0):  w = '{op: OP_TEST,     cond: COND_M_ZERO,      target: PC_ERR};
      PC_W'(1):  w = '{op: OP_TEST,     cond: COND_E_ZERO,      target: PC_ONE};
      PC_W'(2):  w = '{op: OP_REDUCE,   cond: COND_NEVER,       target: '0};
      PC_W'(3):  w = '{op: OP_INIT_ACC, cond: COND_NEVER,       target: '0};
      PC_W'(4):  w = '{op: OP_TEST,     cond: COND_E_LSB_CLEAR, target: PC_SQR};
      PC_W'(5):  w = '{op: OP_MUL_ACC,  cond: COND_NEVER,       target: '0};
      PC_W'(6):  w = '{op: OP_SQR_B,    cond: COND_NEVER,       target: '0};
      PC_W'(7):  w = '{op: OP_SHIFT_E,  cond: COND_E_REST_NZ,   target: PC_LOOP};
      PC_W'(8):  w = '{op: OP_OUT_ACC,  cond: COND_NEVER,       target: '0};
      PC_W'(9):  w = '{op: OP_OUT_ERR,  cond: COND_NEVER,       target: '0};
      PC_W'(10): w = '{op: OP_OUT_ONE,  cond: COND_NEVER,       target: '0};
      default:   w = '{op: OP_OUT_ERR,  cond: COND_NEVER,       target: '0};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/modular_exponentiation_unit.sv
// Channel  | Handshake            | Word
// ---------+----------------------+------------------------------------------
// input    | start & !busy        | base, exponent, modulus
// result   | done (1-cycle pulse) | power_residue, zero_modulus_error
//
// One word at a time. A zero modulus or a zero exponent is answered without any
// modular multiply. Otherwise the modular multiplies run one after another on
// the single shared bit-serial multiply unit: one reduction of the base, then
// per exponent bit one squaring plus one multiply where the bit is set. Reset
// (rst, synchronous) returns the sequencer to idle; the receiver cannot stall
// results.
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPERAND_WIDTH-1:0] base,
  input  logic [OPERAND_WIDTH-1:0] exponent,
  input  logic [OPERAND_WIDTH-1:0] modulus,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] power_residue,
  output logic                     zero_modulus_error
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

  state_t          state;
  logic [PC_W-1:0] pc;
  logic [W-1:0]    b;
  logic [W-1:0]    e;
  logic [W-1:0]    m;
  logic [W-1:0]    acc;

  ucode_t          uw;
  logic            taken;
  logic [PC_W-1:0] pc_next;
  mm_cmd_t         mm_cmd;
  logic [W-1:0]    mm_x;
  logic            mm_done;
  logic [W-1:0]    mm_result;

  assign busy = (state != S_IDLE);

  // Control word fetch and branch resolution
  assign uw = ucode(pc);

  always_comb begin
    case (uw.cond)
      COND_NEVER:       taken = 1'b0;
      COND_ALWAYS:      taken = 1'b1;
      COND_M_ZERO:      taken = (m == '0);
      COND_E_ZERO:      taken = (e == '0);
      COND_E_LSB_CLEAR: taken = !e[0];
      COND_E_REST_NZ:   taken = (e[W-1:1] != '0);
      default:          taken = 1'b0;
    endcase
  end

  assign pc_next = taken ? uw.target : pc + 1'b1;

  // Multiply unit launch and operand select
  assign mm_cmd.go     = (state == S_RUN) &&
                         (uw.op == OP_REDUCE || uw.op == OP_MUL_ACC || uw.op == OP_SQR_B);
  assign mm_cmd.reduce = (uw.op == OP_REDUCE);
  assign mm_x          = (uw.op == OP_MUL_ACC) ? acc : b;

  mexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mm_cmd),
    .x      (mm_x),
    .y      (b),
    .m      (m),
    .done   (mm_done),
    .result (mm_result)
  );

  // Sequencer, datapath registers and result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            b     <= base;
            e     <= exponent;
            m     <= modulus;
            pc    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          case (uw.op)
            OP_TEST: begin
              pc <= pc_next;
            end
            OP_REDUCE, OP_MUL_ACC, OP_SQR_B: begin
              state <= S_WAIT;
            end
            OP_INIT_ACC: begin
              acc <= (m == W'(1)) ? '0 : W'(1);
              pc  <= pc_next;
            end
            OP_SHIFT_E: begin
              e  <= e >> 1;
              pc <= pc_next;
            end
            OP_OUT_ACC: begin
              power_residue      <= acc;
              zero_modulus_error <= 1'b0;
              done               <= 1'b1;
              state              <= S_IDLE;
            end
            OP_OUT_ERR: begin
              power_residue      <= '0;
              zero_modulus_error <= 1'b1;
              done               <= 1'b1;
              state              <= S_IDLE;
            end
            OP_OUT_ONE: begin
              power_residue      <= W'(1);
              zero_modulus_error <= 1'b0;
              done               <= 1'b1;
              state              <= S_IDLE;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_WAIT: begin
          if (mm_done) begin
            if (uw.op == OP_MUL_ACC) begin
              acc <= mm_result;
            end else begin
              b <= mm_result;
            end
            pc    <= pc_next;
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/mexp_mulmod.sv
module mexp_mulmod import mexp_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mm_cmd_t                  cmd,
  input  logic [OPERAND_WIDTH-1:0] x,
  input  logic [OPERAND_WIDTH-1:0] y,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] result
);

  localparam int W     = OPERAND_WIDTH;
  localparam int IDX_W = $clog2(W);

  logic             active;
  logic             phase;    // 0: double, 1: add
  logic             reduce;
  logic [IDX_W-1:0] idx;
  logic [W-1:0]     r;

  logic [W-1:0] addend;
  logic [W:0]   sum;
  logic [W-1:0] sum_mod;

  // One shared add and compare-subtract: r + r or r + addend, both < 2m
  assign addend  = reduce ? W'(1) : x;
  assign sum     = {1'b0, r} + {1'b0, (phase ? addend : r)};
  assign sum_mod = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];

  assign result = r;

  // Bit-serial scan of y, most significant bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        active <= 1'b1;
        phase  <= 1'b0;
        reduce <= cmd.reduce;
        idx    <= IDX_W'(W - 1);
        r      <= '0;
      end else if (active) begin
        r <= sum_mod;
        if (!phase && y[idx]) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          if (idx == '0) begin
            active <= 1'b0;
            done   <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end
    end
  end

endmodule
